// ===== hdl/dtyp_pkg.sv =====
// shared constants, types and arctangent table for the direction to yaw/pitch block
package dtyp_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;
  localparam int FRAC_SHIFT        = 16;
  localparam int GROW_BITS         = 4;
  localparam int GAIN_W            = 18;
  localparam int ACC_W             = 24;
  localparam int ANGLE_EXTRA       = 8;
  localparam int YAW_W             = 16;
  localparam int PITCH_W           = 15;
  localparam int LIMIT_W           = 14;

  typedef logic signed [ACC_W-1:0] angle_acc_t;
  typedef logic signed [YAW_W-1:0] angle_out_t;

  localparam angle_acc_t QUARTER_TURN = 24'sd2949120;
  localparam angle_acc_t ROUND_HALF   = 24'sd128;

  localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 18'sd107922;

  localparam angle_out_t HALF_TURN_OUT = 16'sd23040;

  localparam logic [LIMIT_W-1:0] RIGHT_ANGLE_OUT   = 14'd11520;
  localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RESET = 14'd11392;

  // atan(2^-idx) in 1/32768 degree
  function automatic angle_acc_t atan_entry(input int unsigned idx);
    angle_acc_t val;
    unique case (idx)
      0:       val = 24'sd1474560;
      1:       val = 24'sd870484;
      2:       val = 24'sd459940;
      3:       val = 24'sd233473;
      4:       val = 24'sd117189;
      5:       val = 24'sd58652;
      6:       val = 24'sd29333;
      7:       val = 24'sd14667;
      8:       val = 24'sd7334;
      9:       val = 24'sd3667;
      10:      val = 24'sd1833;
      11:      val = 24'sd917;
      12:      val = 24'sd458;
      13:      val = 24'sd229;
      14:      val = 24'sd115;
      15:      val = 24'sd57;
      16:      val = 24'sd29;
      17:      val = 24'sd14;
      18:      val = 24'sd7;
      19:      val = 24'sd4;
      20:      val = 24'sd2;
      21:      val = 24'sd1;
      default: val = 24'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/dtyp_cordic.sv =====
// pipelined vectoring cordic: half-plane fold then one micro-rotation per stage
module dtyp_cordic #(
  parameter int W      = 36,
  parameter int N      = 16,
  parameter int SIDE_W = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [W-1:0]      in_x,
  input  logic signed [W-1:0]      in_y,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [W-1:0]      out_mag,
  output dtyp_pkg::angle_acc_t     out_acc,
  output logic [SIDE_W-1:0]        out_side
);

  logic                 v_r    [0:N];
  logic                 zero_r [0:N];
  logic signed [W-1:0]  x_r    [0:N];
  logic signed [W-1:0]  y_r    [0:N];
  dtyp_pkg::angle_acc_t acc_r  [0:N];
  logic [SIDE_W-1:0]    side_r [0:N];

  logic                 zero_nxt;
  logic signed [W-1:0]  x_nxt;
  logic signed [W-1:0]  y_nxt;
  dtyp_pkg::angle_acc_t acc_nxt;

  // fold into x >= 0 by an exact quarter turn
  always_comb begin
    zero_nxt = (in_x == '0) && (in_y == '0);
    x_nxt    = in_x;
    y_nxt    = in_y;
    acc_nxt  = '0;
    if (in_x[W-1]) begin
      if (!in_y[W-1]) begin
        x_nxt   = in_y;
        y_nxt   = -in_x;
        acc_nxt = dtyp_pkg::QUARTER_TURN;
      end else begin
        x_nxt   = -in_y;
        y_nxt   = in_x;
        acc_nxt = -dtyp_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    zero_r[0] <= zero_nxt;
    x_r[0]    <= x_nxt;
    y_r[0]    <= y_nxt;
    acc_r[0]  <= acc_nxt;
    side_r[0] <= in_side;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign dx = y_r[g] >>> g;
    assign dy = x_r[g] >>> g;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      zero_r[g+1] <= zero_r[g];
      side_r[g+1] <= side_r[g];
      if (!y_r[g][W-1]) begin
        x_r[g+1]   <= x_r[g] + dx;
        y_r[g+1]   <= y_r[g] - dy;
        acc_r[g+1] <= acc_r[g] + dtyp_pkg::atan_entry(g);
      end else begin
        x_r[g+1]   <= x_r[g] - dx;
        y_r[g+1]   <= y_r[g] + dy;
        acc_r[g+1] <= acc_r[g] - dtyp_pkg::atan_entry(g);
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_mag   = x_r[N];
  assign out_acc   = zero_r[N] ? '0 : acc_r[N];
  assign out_side  = side_r[N];

endmodule

// ===== hdl/direction_to_yaw_pitch.sv =====
// top level: 3-d direction vector to yaw and pitch view angles
//
// Pulse start with in_dir_x/y/z while busy is low; that cycle's vector is
// taken. A new vector may be taken every clock cycle, and vectors never
// wait on one another.
// Each result appears for one cycle with out_valid high, carrying
// out_pitch_angle, out_yaw_angle (1/128 degree) and out_roll_angle (zero).
// The path is a register stage with the z gain multiply, the yaw cordic
// (fold plus one stage per iteration), a yaw rounding stage, the pitch
// cordic, a pitch rounding stage and the clamp/output stage. Throughput
// is one vector per cycle, results leave in order.
// cfg_we with cfg_wdata sets the pitch clamp; write it only while no
// vector is in flight. Values above 90 degrees act as 90 degrees.
// Synchronous reset empties the pipeline, sets the clamp to 89 degrees and
// holds busy high until the cycle after rst_n is released.
// The receiver cannot hold results off, so there is no stall path.
module direction_to_yaw_pitch #(
  parameter int COORD_WIDTH   = dtyp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = dtyp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_z,
  output logic                                out_valid,
  output logic signed [dtyp_pkg::PITCH_W-1:0] out_pitch_angle,
  output logic signed [dtyp_pkg::YAW_W-1:0]   out_yaw_angle,
  output logic                                out_roll_angle,
  input  logic                                cfg_we,
  input  logic [dtyp_pkg::LIMIT_W-1:0]        cfg_wdata
);

  localparam int W      = COORD_WIDTH + dtyp_pkg::FRAC_SHIFT + dtyp_pkg::GROW_BITS;
  localparam int N      = (CORDIC_STAGES < dtyp_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : dtyp_pkg::TABLE_LEN;
  localparam int PROD_W = COORD_WIDTH + dtyp_pkg::GAIN_W;

  logic                          busy_r;
  logic [dtyp_pkg::LIMIT_W-1:0]  pitch_limit_r;

  // input stage
  logic                          va_r;
  logic signed [W-1:0]           xa_r;
  logic signed [W-1:0]           ya_r;
  logic signed [W-1:0]           zga_r;
  logic signed [PROD_W-1:0]      zprod;

  // yaw cordic
  logic                          c1_valid;
  logic signed [W-1:0]           c1_mag;
  dtyp_pkg::angle_acc_t          c1_acc;
  logic [W-1:0]                  c1_side;

  // yaw rounding stage
  dtyp_pkg::angle_acc_t          yaw_sum;
  dtyp_pkg::angle_acc_t          yaw_shift;
  dtyp_pkg::angle_out_t          yaw_rnd;
  dtyp_pkg::angle_out_t          yaw_nxt;
  logic                          vb_r;
  logic signed [W-1:0]           magb_r;
  logic signed [W-1:0]           zgb_r;
  dtyp_pkg::angle_out_t          yawb_r;

  // pitch cordic
  logic                          c2_valid;
  dtyp_pkg::angle_acc_t          c2_acc;
  logic [dtyp_pkg::YAW_W-1:0]    c2_side;

  // pitch rounding stage
  dtyp_pkg::angle_acc_t          pitch_sum;
  dtyp_pkg::angle_acc_t          pitch_shift;
  logic                          vc_r;
  dtyp_pkg::angle_out_t          pitchc_r;
  dtyp_pkg::angle_out_t          yawc_r;

  // clamp stage
  logic [dtyp_pkg::LIMIT_W-1:0]  lim;
  dtyp_pkg::angle_out_t          lim_s;
  dtyp_pkg::angle_out_t          pitch_neg;
  dtyp_pkg::angle_out_t          pitch_nxt;
  logic                          out_valid_r;
  logic signed [dtyp_pkg::PITCH_W-1:0] pitch_out_r;
  dtyp_pkg::angle_out_t          yaw_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      pitch_limit_r <= dtyp_pkg::PITCH_LIMIT_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        pitch_limit_r <= cfg_wdata;
      end
    end
  end

  assign busy  = busy_r;
  assign zprod = in_dir_z * dtyp_pkg::GAIN_Q16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    xa_r  <= {{dtyp_pkg::GROW_BITS{in_dir_x[COORD_WIDTH-1]}}, in_dir_x,
              {dtyp_pkg::FRAC_SHIFT{1'b0}}};
    ya_r  <= {{dtyp_pkg::GROW_BITS{in_dir_y[COORD_WIDTH-1]}}, in_dir_y,
              {dtyp_pkg::FRAC_SHIFT{1'b0}}};
    zga_r <= {{(W-PROD_W){zprod[PROD_W-1]}}, zprod};
  end

  dtyp_cordic #(
    .W      (W),
    .N      (N),
    .SIDE_W (W)
  ) u_yaw_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r),
    .in_x      (xa_r),
    .in_y      (ya_r),
    .in_side   (zga_r),
    .out_valid (c1_valid),
    .out_mag   (c1_mag),
    .out_acc   (c1_acc),
    .out_side  (c1_side)
  );

  always_comb begin
    yaw_sum   = c1_acc + dtyp_pkg::ROUND_HALF;
    yaw_shift = yaw_sum >>> dtyp_pkg::ANGLE_EXTRA;
    yaw_rnd   = yaw_shift[dtyp_pkg::YAW_W-1:0];
    if (yaw_rnd > dtyp_pkg::HALF_TURN_OUT) begin
      yaw_nxt = dtyp_pkg::HALF_TURN_OUT;
    end else if (yaw_rnd < -dtyp_pkg::HALF_TURN_OUT) begin
      yaw_nxt = -dtyp_pkg::HALF_TURN_OUT;
    end else begin
      yaw_nxt = yaw_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    magb_r <= c1_mag;
    zgb_r  <= $signed(c1_side);
    yawb_r <= yaw_nxt;
  end

  dtyp_cordic #(
    .W      (W),
    .N      (N),
    .SIDE_W (dtyp_pkg::YAW_W)
  ) u_pitch_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_x      (magb_r),
    .in_y      (zgb_r),
    .in_side   (yawb_r),
    .out_valid (c2_valid),
    .out_mag   (),
    .out_acc   (c2_acc),
    .out_side  (c2_side)
  );

  always_comb begin
    pitch_sum   = c2_acc + dtyp_pkg::ROUND_HALF;
    pitch_shift = pitch_sum >>> dtyp_pkg::ANGLE_EXTRA;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    pitchc_r <= pitch_shift[dtyp_pkg::YAW_W-1:0];
    yawc_r   <= $signed(c2_side);
  end

  // pitch is minus the elevation, then clamped
  always_comb begin
    lim       = (pitch_limit_r > dtyp_pkg::RIGHT_ANGLE_OUT) ?
                dtyp_pkg::RIGHT_ANGLE_OUT : pitch_limit_r;
    lim_s     = $signed({{(dtyp_pkg::YAW_W-dtyp_pkg::LIMIT_W){1'b0}}, lim});
    pitch_neg = -pitchc_r;
    if (pitch_neg > lim_s) begin
      pitch_nxt = lim_s;
    end else if (pitch_neg < -lim_s) begin
      pitch_nxt = -lim_s;
    end else begin
      pitch_nxt = pitch_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    pitch_out_r <= pitch_nxt[dtyp_pkg::PITCH_W-1:0];
    yaw_out_r   <= yawc_r;
  end

  assign out_valid       = out_valid_r;
  assign out_pitch_angle = pitch_out_r;
  assign out_yaw_angle   = yaw_out_r;
  assign out_roll_angle  = 1'b0;

endmodule

// ===== hdl/dtyp_checker.sv =====
// port-level checker for the direction to yaw/pitch block, with its bind
module dtyp_checker #(
  parameter int COORD_WIDTH = dtyp_pkg::COORD_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic signed [COORD_WIDTH-1:0]       in_dir_x,
  input logic signed [COORD_WIDTH-1:0]       in_dir_y,
  input logic signed [COORD_WIDTH-1:0]       in_dir_z,
  input logic                                out_valid,
  input logic signed [dtyp_pkg::PITCH_W-1:0] out_pitch_angle,
  input logic signed [dtyp_pkg::YAW_W-1:0]   out_yaw_angle,
  input logic                                out_roll_angle,
  input logic                                cfg_we,
  input logic [dtyp_pkg::LIMIT_W-1:0]        cfg_wdata
);

  // no result transfer right after a reset cycle
  a_no_out_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result transfer right after reset");

  // input side never blocks once out of reset
  a_never_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy outside reset");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= 16'sd23040) && (out_yaw_angle >= -16'sd23040))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 15'sd11520) && (out_pitch_angle >= -15'sd11520))
    else $error("pitch beyond right angle");

  a_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_roll_angle)
    else $error("roll not zero");

endmodule

bind direction_to_yaw_pitch dtyp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_dtyp_checker (.*);

// ===== tb/sv/direction_to_yaw_pitch_test.sv =====
// self-checking testbench for direction_to_yaw_pitch with a scoreboard of predicted view angles
`timescale 1ns / 100ps

module direction_to_yaw_pitch_test;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    logic signed [dtyp_pkg::PITCH_W-1:0] pitch;
    logic signed [dtyp_pkg::YAW_W-1:0]   yaw;
    logic                                roll;
  } view_angles_t;

  class angle_scoreboard;
    localparam int     STEPS      = 16;
    localparam longint QUARTER    = 64'sd2949120;
    localparam longint GAIN       = 64'sd107922;
    localparam longint YAW_MAX    = 64'sd23040;
    localparam longint PITCH_MAX  = 64'sd11520;

    view_angles_t expected_angles[$];
    logic [dtyp_pkg::LIMIT_W-1:0] pitch_clamp;
    int mismatches;

    function new();
      pitch_clamp = 14'd11392;
      mismatches  = 0;
    endfunction

    function longint atan_step(int i);
      longint v;
      case (i)
        0:  v = 1474560;
        1:  v = 870484;
        2:  v = 459940;
        3:  v = 233473;
        4:  v = 117189;
        5:  v = 58652;
        6:  v = 29333;
        7:  v = 14667;
        8:  v = 7334;
        9:  v = 3667;
        10: v = 1833;
        11: v = 917;
        12: v = 458;
        13: v = 229;
        14: v = 115;
        15: v = 57;
        16: v = 29;
        17: v = 14;
        18: v = 7;
        19: v = 4;
        20: v = 2;
        21: v = 1;
        default: v = 0;
      endcase
      return v;
    endfunction

    // vectoring rotation: angle in 1/32768 degree, scaled length in mag
    function longint rotate_to_axis(input longint x0, input longint y0, output longint mag);
      longint x, y, acc, t, dx, dy;
      int i;
      x = x0;
      y = y0;
      acc = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          acc = QUARTER;
        end else begin
          x = -y;
          y = t;
          acc = -QUARTER;
        end
      end
      for (i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          acc = acc + atan_step(i);
        end else begin
          x = x - dx;
          y = y + dy;
          acc = acc - atan_step(i);
        end
      end
      mag = x;
      return acc;
    endfunction

    function longint round_angle(longint acc);
      return (acc + 128) >>> 8;
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function view_angles_t predict_angles(coord_t dir_x, coord_t dir_y, coord_t dir_z);
      longint x, y, z, hmag, unused_mag, yaw, pitch, lim;
      view_angles_t r;
      x = dir_x;
      y = dir_y;
      z = dir_z;
      yaw = clamp(round_angle(rotate_to_axis(x * 65536, y * 65536, hmag)), YAW_MAX);
      pitch = -round_angle(rotate_to_axis(hmag, z * GAIN, unused_mag));
      lim = pitch_clamp;
      if (lim > PITCH_MAX) lim = PITCH_MAX;
      pitch = clamp(pitch, lim);
      r.pitch = pitch[dtyp_pkg::PITCH_W-1:0];
      r.yaw   = yaw[dtyp_pkg::YAW_W-1:0];
      r.roll  = 1'b0;
      return r;
    endfunction

    function void note_vector(coord_t dir_x, coord_t dir_y, coord_t dir_z);
      expected_angles.push_back(predict_angles(dir_x, dir_y, dir_z));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_angles(logic signed [dtyp_pkg::PITCH_W-1:0] pitch,
                               logic signed [dtyp_pkg::YAW_W-1:0] yaw,
                               logic roll);
      view_angles_t want;
      if (expected_angles.size() == 0) begin
        report($sformatf("unexpected result pitch %0d yaw %0d roll %0b", pitch, yaw, roll));
        return;
      end
      want = expected_angles.pop_front();
      if (want.pitch !== pitch || want.yaw !== yaw || want.roll !== roll)
        report($sformatf("pitch %0d/%0d yaw %0d/%0d roll %0b/%0b (expected/actual)",
                         want.pitch, pitch, want.yaw, yaw, want.roll, roll));
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  localparam int N_DIRECTED = 22;
  localparam coord_t DIR_X [N_DIRECTED] = '{
    16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768,
    16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd1, -16'sd1, 16'sd0, 16'sd0,
    16'sd1, 16'sd100, -16'sd5, 16'sd32767, -16'sd1, 16'sd3
  };
  localparam coord_t DIR_Y [N_DIRECTED] = '{
    16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd32768,
    16'sd32767, 16'sd32767, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd1, -16'sd100, 16'sd7, -16'sd32768, -16'sd1, -16'sd4
  };
  localparam coord_t DIR_Z [N_DIRECTED] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0, -16'sd32768,
    16'sd32767, 16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd1, -16'sd1,
    -16'sd32768, 16'sd100, 16'sd32767, 16'sd12345, -16'sd32768, 16'sd5
  };

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  coord_t                              in_dir_x;
  coord_t                              in_dir_y;
  coord_t                              in_dir_z;
  logic                                out_valid;
  logic signed [dtyp_pkg::PITCH_W-1:0] out_pitch_angle;
  logic signed [dtyp_pkg::YAW_W-1:0]   out_yaw_angle;
  logic                                out_roll_angle;
  logic                                cfg_we;
  logic [dtyp_pkg::LIMIT_W-1:0]        cfg_wdata;

  angle_scoreboard sb = new();

  direction_to_yaw_pitch dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .out_valid       (out_valid),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_roll_angle  (out_roll_angle),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_vector(in_dir_x, in_dir_y, in_dir_z);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_angles(out_pitch_angle, out_yaw_angle, out_roll_angle);
  end

  task automatic send_vector(coord_t x, coord_t y, coord_t z, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_dir_x = x;
    in_dir_y = y;
    in_dir_z = z;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_pitch_limit(logic [dtyp_pkg::LIMIT_W-1:0] v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 14'($urandom);
    sb.pitch_clamp = v;
  endtask

  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(0, 9)) inside
      [0:4]: v = coord_t'($urandom);
      [5:6]: v = coord_t'($urandom_range(0, 32) - 16);
      7:     v = 16'sd0;
      8: begin
        case ($urandom_range(0, 4))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = -16'sd1;
          3: v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      default: v = coord_t'($urandom_range(0, 255) - 16'sd32768 +
                            (($urandom_range(0, 1) == 1) ? 16'sd0 : -16'sd256));
    endcase
    return v;
  endfunction

  task automatic random_vectors(int count);
    coord_t x, y, z;
    bit burst;
    int n;
    burst = 1'b0;
    for (n = 0; n < count; n++) begin
      if (n % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      if ($urandom_range(0, 15) == 0) begin
        x = 16'sd0;
        y = 16'sd0;
      end
      send_vector(x, y, z, burst ? 0 : $urandom_range(0, 12));
    end
  endtask

  initial begin
    logic [dtyp_pkg::LIMIT_W-1:0] limits [7];
    int k;
    rst_n = 1'b0;
    start = 1'b0;
    in_dir_x = '0;
    in_dir_y = '0;
    in_dir_z = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    limits = '{14'd0, 14'd16383, 14'd11520, 14'd1, 14'd11519, 14'd5760, 14'd11392};
    limits[5] = 14'($urandom_range(0, 16383));
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < N_DIRECTED; k++)
      send_vector(DIR_X[k], DIR_Y[k], DIR_Z[k], $urandom_range(0, 3));
    random_vectors(60);

    for (k = 0; k < 7; k++) begin
      write_pitch_limit(limits[k]);
      random_vectors(84);
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("direction_to_yaw_pitch_test: done, clean");
    end else begin
      $display("direction_to_yaw_pitch_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("direction_to_yaw_pitch_test: done, errors");
    $finish;
  end

endmodule
